// ----- design/flt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flt_pkg
// Shared widths, codes and control/status types of the line tessellator.
// ----------------------------------------------------------------------------
package flt_pkg;

    // field widths
    localparam int COORD_W  = 24;
    localparam int DIFF_W   = 25;
    localparam int MAG_W    = 24;
    localparam int LW_W     = 23;
    localparam int WGT_W    = 25;
    localparam int SQ_W     = 48;
    localparam int RAD_W    = 58;
    localparam int ROOT_W   = 29;
    localparam int REM_W    = 31;
    localparam int PROD_W   = 49;
    localparam int NUM_W    = 53;
    localparam int Q_W      = 26;
    localparam int OFF_W    = 27;
    localparam int SUM_W    = 28;
    localparam int COL_W    = 32;
    localparam int SLOT_W   = 12;
    localparam int VTX_W    = 13;
    localparam int IDX_W    = 15;
    localparam int CFG_W    = 15;
    localparam int ITEM_W   = 4;
    localparam int STEP_W   = 5;

    // iteration counts
    localparam int SQRT_STEPS = 29;
    localparam int DIV_STEPS  = 26;
    localparam int ITEMS      = 14;

    // capacity
    localparam int MAX_VERTICES = 4096;
    localparam int MAX_INDICES  = 16384;
    localparam int VTX_STEP     = 8;
    localparam int IDX_STEP     = 18;

    // operation codes
    localparam logic OP_DRAW  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // register indexes
    localparam logic REG_VERTEX_LIMIT = 1'b0;
    localparam logic REG_INDEX_LIMIT  = 1'b1;

    // offset selects
    localparam logic [1:0] SEL_HX = 2'd0;
    localparam logic [1:0] SEL_HY = 2'd1;
    localparam logic [1:0] SEL_SX = 2'd2;
    localparam logic [1:0] SEL_SY = 2'd3;

    typedef struct packed {
        logic              latch;
        logic              clear;
        logic              diff;
        logic              square;
        logic              sqrt_init;
        logic              sqrt_step;
        logic              div_load;
        logic              div_step;
        logic              div_store;
        logic [1:0]        sel;
        logic              load_out;
        logic [ITEM_W-1:0] item;
        logic              commit;
    } cmd_t;

    typedef struct packed {
        logic no_room;
        logic zero_len;
    } sts_t;

endpackage
`default_nettype wire

// ----- design/flt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flt_ctrl
// Sequencer: accepts beats, steps the root and divide loops, emits 14 items.
// ----------------------------------------------------------------------------
module flt_ctrl
    import flt_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire logic operation,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      cmd,
    input  sts_t      sts
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_SQUARE = 3'd2;
    localparam logic [2:0] S_INIT   = 3'd3;
    localparam logic [2:0] S_SQRT   = 3'd4;
    localparam logic [2:0] S_LOAD   = 3'd5;
    localparam logic [2:0] S_DIV    = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        sel_reg, sel_next;
    logic [ITEM_W-1:0] item_reg, item_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        sel_next   = sel_reg;
        item_next  = item_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        cmd.item   = item_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.latch = 1'b1;
                    if (operation == OP_CLEAR)
                    begin
                        cmd.clear = 1'b1;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                cmd.diff = 1'b1;
                if (sts.no_room || sts.zero_len)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SQUARE;
                end
            end
            S_SQUARE:
            begin
                cmd.square = 1'b1;
                state_next = S_INIT;
            end
            S_INIT:
            begin
                cmd.sqrt_init = 1'b1;
                step_next     = '0;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    sel_next   = SEL_HX;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    cmd.div_store = 1'b1;
                    if (sel_reg == SEL_SY)
                    begin
                        item_next  = '0;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        sel_next   = sel_reg + 1'b1;
                        state_next = S_LOAD;
                    end
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    item_next    = item_reg + 1'b1;
                    if (item_reg == ITEM_W'(ITEMS - 1))
                    begin
                        cmd.commit = 1'b1;
                        item_next  = '0;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            sel_reg       <= SEL_HX;
            item_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            sel_reg       <= sel_next;
            item_reg      <= item_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while stalled");
    a_last_item: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && item_reg == ITEM_W'(ITEMS - 1)) |=> state_reg == S_IDLE)
        else $error("sequencer did not return to idle after the last item");
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_CLEAR) |=> state_reg == S_IDLE)
        else $error("clear beat left the sequencer busy");
    a_root_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SQRT && step_reg == STEP_W'(SQRT_STEPS - 1))
        |=> (state_reg == S_LOAD && sel_reg == SEL_HX))
        else $error("root loop did not hand over to the first divide");
`endif

endmodule
`default_nettype wire

// ----- design/flt_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flt_dp
// Datapath: operand latch, capacity check, bitwise root, shared divider,
// vertex/triangle formation, output register and mesh counters.
// ----------------------------------------------------------------------------
module flt_dp
    import flt_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic                      cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data,
    input  wire logic signed [COORD_W-1:0] start_x,
    input  wire logic signed [COORD_W-1:0] start_y,
    input  wire logic signed [COORD_W-1:0] end_x,
    input  wire logic signed [COORD_W-1:0] end_y,
    input  wire logic [LW_W-1:0]           line_width,
    input  wire logic [LW_W-1:0]           feather_width,
    input  wire logic [COL_W-1:0]          colour_in,
    input  cmd_t                           cmd,
    output sts_t                           sts,
    output logic                           is_triangle,
    output logic signed [COORD_W-1:0]      vertex_x,
    output logic signed [COORD_W-1:0]      vertex_y,
    output logic [COL_W-1:0]               vertex_colour,
    output logic [SLOT_W-1:0]              vertex_number,
    output logic [SLOT_W-1:0]              tri_a,
    output logic [SLOT_W-1:0]              tri_b,
    output logic [SLOT_W-1:0]              tri_c,
    output logic                           last
);

    // configuration and counters
    logic [VTX_W-1:0] vlimit_reg, vtotal_reg;
    logic [IDX_W-1:0] ilimit_reg, itotal_reg;
    logic [VTX_W-1:0] vlimit_eff;
    logic [IDX_W-1:0] ilimit_eff;

    // operands
    logic signed [COORD_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic [LW_W-1:0]           half_reg, feather_reg;
    logic [COL_W-1:0]          colour_reg;
    logic signed [DIFF_W-1:0]  dx, dy;
    logic [MAG_W-1:0]          magx_reg, magy_reg;
    logic                      dxneg_reg, dyneg_reg;
    logic [SQ_W-1:0]           sqx_reg, sqy_reg;

    // root
    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  srem_reg, srem_shift, strial;

    // divider
    logic [WGT_W-1:0]  outer_wgt;
    logic [WGT_W-1:0]  wgt;
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [NUM_W-1:0]  num;
    logic [ROOT_W-1:0] drem_reg, drem_next;
    logic [ROOT_W:0]   drem_shift;
    logic [Q_W-1:0]    dlow_reg, quo_reg, quo_next;
    logic              dge, negate;
    logic signed [OFF_W-1:0] hx_reg, hy_reg, sx_reg, sy_reg, off_new;

    // item formation
    logic signed [COORD_W-1:0] ex, ey;
    logic signed [OFF_W-1:0]   ox, oy;
    logic signed [SUM_W-1:0]   px, py;
    logic [2:0]                tnum;
    logic [1:0]                qk;
    logic [SLOT_W-1:0]         base;

    // capacity check against effective limits
    assign vlimit_eff = (vlimit_reg > VTX_W'(MAX_VERTICES)) ? VTX_W'(MAX_VERTICES) : vlimit_reg;
    assign ilimit_eff = (ilimit_reg > IDX_W'(MAX_INDICES)) ? IDX_W'(MAX_INDICES) : ilimit_reg;
    assign sts.no_room =
        (({1'b0, vtotal_reg} + (VTX_W + 1)'(VTX_STEP)) > {1'b0, vlimit_eff}) ||
        (({1'b0, itotal_reg} + (IDX_W + 1)'(IDX_STEP)) > {1'b0, ilimit_eff});
    assign sts.zero_len = (x1_reg == x2_reg) && (y1_reg == y2_reg);

    assign dx = DIFF_W'(x2_reg) - DIFF_W'(x1_reg);
    assign dy = DIFF_W'(y2_reg) - DIFF_W'(y1_reg);

    // config and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vlimit_reg <= VTX_W'(MAX_VERTICES);
            ilimit_reg <= IDX_W'(MAX_INDICES);
            vtotal_reg <= '0;
            itotal_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_VERTEX_LIMIT: vlimit_reg <= cfg_data[VTX_W-1:0];
                    REG_INDEX_LIMIT:  ilimit_reg <= cfg_data[IDX_W-1:0];
                    default:          vlimit_reg <= vlimit_reg;
                endcase
            end
            if (cmd.clear)
            begin
                vtotal_reg <= '0;
                itotal_reg <= '0;
            end
            else if (cmd.commit)
            begin
                vtotal_reg <= vtotal_reg + VTX_W'(VTX_STEP);
                itotal_reg <= itotal_reg + IDX_W'(IDX_STEP);
            end
        end
    end

    // root step: bring down two bits, try subtract
    assign srem_shift = {srem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign strial     = {root_reg, 2'b01};

    // divider operands and step
    assign outer_wgt = WGT_W'(half_reg) + {1'b0, feather_reg, 1'b0};
    always_comb
    begin
        mag    = magx_reg;
        wgt    = WGT_W'(half_reg);
        negate = dxneg_reg;
        case (cmd.sel)
            SEL_HX:
            begin
                mag    = magy_reg;
                negate = !dyneg_reg;
            end
            SEL_HY:
            begin
                mag    = magx_reg;
                negate = dxneg_reg;
            end
            SEL_SX:
            begin
                mag    = magy_reg;
                wgt    = outer_wgt;
                negate = !dyneg_reg;
            end
            default:
            begin
                mag    = magx_reg;
                wgt    = outer_wgt;
                negate = dxneg_reg;
            end
        endcase
    end
    assign prod = PROD_W'(mag) * PROD_W'(wgt);
    assign num  = NUM_W'({prod, 3'b000}) + NUM_W'(root_reg >> 1);

    assign drem_shift = {drem_reg, dlow_reg[Q_W-1]};
    assign dge        = drem_shift >= {1'b0, root_reg};
    assign drem_next  = dge ? ROOT_W'(drem_shift - {1'b0, root_reg}) : drem_shift[ROOT_W-1:0];
    assign quo_next   = {quo_reg[Q_W-2:0], dge};
    assign off_new    = negate ? -OFF_W'(quo_next) : OFF_W'(quo_next);

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            x1_reg      <= start_x;
            y1_reg      <= start_y;
            x2_reg      <= end_x;
            y2_reg      <= end_y;
            half_reg    <= line_width;
            feather_reg <= feather_width;
            colour_reg  <= colour_in;
        end
        if (cmd.diff)
        begin
            dxneg_reg <= dx[DIFF_W-1];
            dyneg_reg <= dy[DIFF_W-1];
            magx_reg  <= MAG_W'(dx[DIFF_W-1] ? -dx : dx);
            magy_reg  <= MAG_W'(dy[DIFF_W-1] ? -dy : dy);
        end
        if (cmd.square)
        begin
            sqx_reg <= SQ_W'(magx_reg) * SQ_W'(magx_reg);
            sqy_reg <= SQ_W'(magy_reg) * SQ_W'(magy_reg);
        end
        if (cmd.sqrt_init)
        begin
            rad_reg  <= RAD_W'({({1'b0, sqx_reg} + {1'b0, sqy_reg}), 8'h00});
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg <= rad_reg << 2;
            if (srem_shift >= strial)
            begin
                srem_reg <= srem_shift - strial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                srem_reg <= srem_shift;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.div_load)
        begin
            drem_reg <= ROOT_W'(num[NUM_W-1:Q_W]);
            dlow_reg <= num[Q_W-1:0];
            quo_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            drem_reg <= drem_next;
            dlow_reg <= dlow_reg << 1;
            quo_reg  <= quo_next;
        end
        if (cmd.div_store)
        begin
            case (cmd.sel)
                SEL_HX:  hx_reg <= off_new;
                SEL_HY:  hy_reg <= off_new;
                SEL_SX:  sx_reg <= off_new;
                default: sy_reg <= off_new;
            endcase
        end
    end

    // vertex position for the current item
    always_comb
    begin
        ex = cmd.item[2] ? x2_reg : x1_reg;
        ey = cmd.item[2] ? y2_reg : y1_reg;
        case (cmd.item[1:0])
            2'd0:
            begin
                ox = sx_reg;
                oy = sy_reg;
            end
            2'd1:
            begin
                ox = hx_reg;
                oy = hy_reg;
            end
            2'd2:
            begin
                ox = -hx_reg;
                oy = -hy_reg;
            end
            default:
            begin
                ox = -sx_reg;
                oy = -sy_reg;
            end
        endcase
        px = SUM_W'(ex) + SUM_W'(ox);
        py = SUM_W'(ey) + SUM_W'(oy);
    end

    function automatic logic signed [COORD_W-1:0] sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
        lo = -hi - SUM_W'(1);
        if (v > hi)
        begin
            sat = COORD_W'(hi);
        end
        else if (v < lo)
        begin
            sat = COORD_W'(lo);
        end
        else
        begin
            sat = COORD_W'(v);
        end
    endfunction

    assign base = vtotal_reg[SLOT_W-1:0];
    assign tnum = 3'(cmd.item - ITEM_W'(VTX_STEP));
    assign qk   = tnum[2:1];

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            is_triangle   <= cmd.item[3];
            last          <= (cmd.item == ITEM_W'(ITEMS - 1));
            if (!cmd.item[3])
            begin
                vertex_x      <= sat(px);
                vertex_y      <= sat(py);
                vertex_colour <= (cmd.item[1:0] == 2'd0 || cmd.item[1:0] == 2'd3)
                                 ? {colour_reg[COL_W-1:8], 8'h00} : colour_reg;
                vertex_number <= base + SLOT_W'(cmd.item);
                tri_a         <= '0;
                tri_b         <= '0;
                tri_c         <= '0;
            end
            else
            begin
                vertex_x      <= '0;
                vertex_y      <= '0;
                vertex_colour <= '0;
                vertex_number <= '0;
                tri_a         <= base + SLOT_W'(qk);
                tri_b         <= base + SLOT_W'(qk) + (tnum[0] ? SLOT_W'(5) : SLOT_W'(1));
                tri_c         <= base + SLOT_W'(qk) + (tnum[0] ? SLOT_W'(4) : SLOT_W'(5));
            end
        end
    end

endmodule
`default_nettype wire

// ----- design/feathered_line_tessellator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// feathered_line_tessellator
// Thick line tessellation with feathered edges into a vertex/triangle stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one beat per operation: draw a
//   segment or clear the mesh counters. in_ready is high only while the
//   sequencer is idle, so one operation is in work at a time.
//   Output channel (out_valid/out_ready) gives 8 vertex beats then 6
//   triangle beats per drawn segment; last marks the fourteenth beat.
//   A draw runs a check, a square, a root setup and 29 root steps, then a
//   divider load and 26 divide steps for each of the four offsets, then the
//   14 item emits; the bitwise root and the single shared divider set its length.
//   A clear, a segment without room, or a zero-length segment produces no
//   beat.
//   When the receiver stalls, the output register holds its beat and the
//   sequencer waits; the last beat may still wait while the next input is
//   taken. Reset sets the limits to 4096 and 16384 and zeroes the counters.
//   Config writes (cfg_write, cfg_index, cfg_data) take effect at once; the user
//   must issue them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module feathered_line_tessellator
    import flt_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic                      cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      operation,
    input  wire logic signed [COORD_W-1:0] start_x,
    input  wire logic signed [COORD_W-1:0] start_y,
    input  wire logic signed [COORD_W-1:0] end_x,
    input  wire logic signed [COORD_W-1:0] end_y,
    input  wire logic [LW_W-1:0]           line_width,
    input  wire logic [LW_W-1:0]           feather_width,
    input  wire logic [COL_W-1:0]          colour_in,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic                           is_triangle,
    output logic signed [COORD_W-1:0]      vertex_x,
    output logic signed [COORD_W-1:0]      vertex_y,
    output logic [COL_W-1:0]               vertex_colour,
    output logic [SLOT_W-1:0]              vertex_number,
    output logic [SLOT_W-1:0]              tri_a,
    output logic [SLOT_W-1:0]              tri_b,
    output logic [SLOT_W-1:0]              tri_c,
    output logic                           last
);

    cmd_t cmd;
    sts_t sts;

    // sequencer
    flt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // arithmetic and output register
    flt_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .line_width    (line_width),
        .feather_width (feather_width),
        .colour_in     (colour_in),
        .cmd           (cmd),
        .sts           (sts),
        .is_triangle   (is_triangle),
        .vertex_x      (vertex_x),
        .vertex_y      (vertex_y),
        .vertex_colour (vertex_colour),
        .vertex_number (vertex_number),
        .tri_a         (tri_a),
        .tri_b         (tri_b),
        .tri_c         (tri_c),
        .last          (last)
    );

endmodule
`default_nettype wire

// ----- dv/tb_feathered_line_tessellator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_feathered_line_tessellator
// Drives draw and clear operations into the line tessellator, predicts the
// fourteen-beat vertex/triangle stream of each drawn segment, and checks
// every output beat field by field, under random valid/ready idling.
// ----------------------------------------------------------------------------
module tb_feathered_line_tessellator;
    import flt_pkg::*;

    typedef struct {
        logic                      op;
        logic signed [COORD_W-1:0] x1, y1, x2, y2;
        logic [LW_W-1:0]           lw, fw;
        logic [COL_W-1:0]          col;
        int                        cfg_sel;   // -1 none, else register written before
        logic [CFG_W-1:0]          cfg_val;
        bit                        drain;     // wait until all beats have come
    } seg_t;

    typedef struct {
        logic                      tri_flag;
        logic signed [COORD_W-1:0] vx, vy;
        logic [COL_W-1:0]          vc;
        logic [SLOT_W-1:0]         vn, ta, tb, tc;
        logic                      lst;
    } beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic operation = 1'b0;
    logic signed [COORD_W-1:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
    logic [LW_W-1:0] line_width = '0, feather_width = '0;
    logic [COL_W-1:0] colour_in = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic is_triangle;
    logic signed [COORD_W-1:0] vertex_x, vertex_y;
    logic [COL_W-1:0] vertex_colour;
    logic [SLOT_W-1:0] vertex_number, tri_a, tri_b, tri_c;
    logic last;

    feathered_line_tessellator DUT (.*);

    seg_t  pending_segs[$];
    beat_t mesh_beats[$];
    int    errors = 0;
    int    send_idle = 17, recv_idle = 86;
    int    stall = 0;
    bit    stim_done = 1'b0;

    // acceptance seen at the rising edge, drain hold and quiet-cycle count
    logic in_ready_q = 1'b0;
    logic hold_off = 1'b0;
    int   quiet = 0;
    int   taken = 0;

    // mesh predictor state
    logic [VTX_W-1:0] lim_vtx = 13'd4096, vtx_total = '0;
    logic [IDX_W-1:0] lim_idx = 15'd16384, idx_total = '0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic longint unsigned int_root(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint offset_of(longint d, longint unsigned w,
                                         longint unsigned len);
        longint unsigned m, q;
        m = (d < 0) ? -d : d;
        q = (m * w * 8 + len / 2) / len;
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [COORD_W-1:0] clamp24(longint v);
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        return v[COORD_W-1:0];
    endfunction

    // predict the beats of one operation and update the counters
    task automatic tessellate(input seg_t s);
        longint dx, dy, hx, hy, sx, sy, ex, ey;
        longint unsigned sq, len, half, outer, ev, ei;
        longint px[8], py[8];
        logic [COL_W-1:0] pc[8];
        beat_t b;
        int q[3][4];
        q = '{'{0, 1, 5, 4}, '{1, 2, 6, 5}, '{2, 3, 7, 6}};
        if (s.op == OP_CLEAR)
        begin
            vtx_total = '0;
            idx_total = '0;
            return;
        end
        ev = (lim_vtx > MAX_VERTICES) ? MAX_VERTICES : lim_vtx;
        ei = (lim_idx > MAX_INDICES) ? MAX_INDICES : lim_idx;
        if (vtx_total + 8 > ev || idx_total + 18 > ei) return;
        dx = longint'(s.x2) - longint'(s.x1);
        dy = longint'(s.y2) - longint'(s.y1);
        sq = dx * dx + dy * dy;
        if (sq == 0) return;
        len = int_root(sq << 8);
        half = s.lw;
        outer = half + 2 * longint'(s.fw);
        hx = -offset_of(dy, half, len);
        hy = offset_of(dx, half, len);
        sx = -offset_of(dy, outer, len);
        sy = offset_of(dx, outer, len);
        for (int k = 0; k < 2; k++)
        begin
            ex = k ? s.x2 : s.x1;
            ey = k ? s.y2 : s.y1;
            px[4*k]   = ex + sx; py[4*k]   = ey + sy; pc[4*k]   = {s.col[31:8], 8'h00};
            px[4*k+1] = ex + hx; py[4*k+1] = ey + hy; pc[4*k+1] = s.col;
            px[4*k+2] = ex - hx; py[4*k+2] = ey - hy; pc[4*k+2] = s.col;
            px[4*k+3] = ex - sx; py[4*k+3] = ey - sy; pc[4*k+3] = {s.col[31:8], 8'h00};
        end
        for (int i = 0; i < 8; i++)
        begin
            b = '{1'b0, clamp24(px[i]), clamp24(py[i]), pc[i],
                  SLOT_W'(vtx_total + i), '0, '0, '0, 1'b0};
            mesh_beats.push_back(b);
        end
        for (int k = 0; k < 3; k++)
            for (int i = 0; i < 2; i++)
            begin
                b = '{1'b1, '0, '0, '0, '0, SLOT_W'(vtx_total + q[k][0]),
                      SLOT_W'(vtx_total + q[k][1+i]), SLOT_W'(vtx_total + q[k][2+i]),
                      (k == 2 && i == 1)};
                mesh_beats.push_back(b);
            end
        vtx_total = VTX_W'(vtx_total + 8);
        idx_total = IDX_W'(idx_total + 18);
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic seg_t rand_seg(input int mode);
        seg_t s;
        logic [COORD_W-1:0] span;
        s.op = ($urandom_range(0, 19) == 0) ? OP_CLEAR : OP_DRAW;
        s.x1 = COORD_W'($urandom); s.y1 = COORD_W'($urandom);
        if (mode == 0)
        begin
            span = $urandom_range(0, 4) == 0 ? 24'hFFFFFF : 24'h000FFF;
            s.x2 = COORD_W'(s.x1 + ($urandom & span) - (span >> 1));
            s.y2 = COORD_W'(s.y1 + ($urandom & span) - (span >> 1));
        end
        else
        begin
            s.x2 = COORD_W'($urandom); s.y2 = COORD_W'($urandom);
        end
        if ($urandom_range(0, 15) == 0) begin s.x2 = s.x1; s.y2 = s.y1; end
        s.lw = ($urandom_range(0, 3) == 0) ? LW_W'($urandom) : LW_W'($urandom_range(0, 4095));
        s.fw = ($urandom_range(0, 3) == 0) ? LW_W'($urandom) : LW_W'($urandom_range(0, 2047));
        s.col = $urandom;
        s.cfg_sel = -1;
        s.cfg_val = '0;
        s.drain = 1'b0;
        return s;
    endfunction

    function automatic seg_t plain(input logic signed [COORD_W-1:0] a, b, c, d,
                                   input logic [LW_W-1:0] w, f);
        seg_t s;
        s = '{OP_DRAW, a, b, c, d, w, f, $urandom, -1, '0, 1'b0};
        return s;
    endfunction

    // fill the stimulus queue
    initial
    begin
        seg_t s;
        pending_segs.push_back(plain(0, 0, 24'sd2560, 0, 23'd512, 23'd256));
        pending_segs.push_back(plain(0, 0, 0, 24'sd2560, 23'd512, 23'd256));
        pending_segs.push_back(plain(24'sd100, 24'sd100, 24'sd100, 24'sd100, 23'd512, 0));
        pending_segs.push_back(plain(24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF,
                                     23'h7FFFFF, 23'h7FFFFF));
        pending_segs.push_back(plain(24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF,
                                     23'h7FFFFF, 0));
        pending_segs.push_back(plain(24'sh7FFFFF, 0, 24'sh7FFFFE, 0, 0, 23'h7FFFFF));
        pending_segs.push_back(plain(-24'sd1, -24'sd1, 24'sd1, 24'sd1, 23'd1, 23'd1));
        s = plain(0, 0, 24'sd7, 24'sd3, 23'd300, 23'd20); s.col = 32'hFFFFFFFF;
        pending_segs.push_back(s);
        s = plain(0, 0, 24'sd7, 24'sd3, 23'd300, 23'd20); s.col = 32'h0;
        pending_segs.push_back(s);
        // limits: vertex limit of 16 is below the vertices already drawn, so blocked, then clear
        s = plain(0, 0, 24'sd50, 24'sd9, 23'd64, 23'd64);
        s.cfg_sel = REG_VERTEX_LIMIT; s.cfg_val = 15'd16; s.drain = 1'b1;
        pending_segs.push_back(s);
        for (int i = 0; i < 3; i++) pending_segs.push_back(rand_seg(0));
        s = rand_seg(0); s.op = OP_CLEAR; pending_segs.push_back(s);
        s = plain(0, 0, 24'sd9, 24'sd50, 23'd64, 23'd64);
        s.cfg_sel = REG_VERTEX_LIMIT; s.cfg_val = 15'h1FFF; s.drain = 1'b1;
        pending_segs.push_back(s);
        s = plain(0, 0, 24'sd9, 24'sd50, 23'd64, 23'd64);
        s.cfg_sel = REG_INDEX_LIMIT; s.cfg_val = 15'd35; s.drain = 1'b1;
        pending_segs.push_back(s);
        pending_segs.push_back(plain(0, 0, 24'sd9, 24'sd51, 23'd64, 23'd64));
        s = rand_seg(0); s.op = OP_CLEAR; pending_segs.push_back(s);
        s = plain(0, 0, 24'sd9, 24'sd50, 23'd64, 23'd64);
        s.cfg_sel = REG_INDEX_LIMIT; s.cfg_val = 15'd0; s.drain = 1'b1;
        pending_segs.push_back(s);
        s = plain(0, 0, 24'sd9, 24'sd50, 23'd64, 23'd64);
        s.cfg_sel = REG_VERTEX_LIMIT; s.cfg_val = 15'd0; s.drain = 1'b1;
        pending_segs.push_back(s);
        s = plain(0, 0, 24'sd9, 24'sd50, 23'd64, 23'd64);
        s.cfg_sel = REG_INDEX_LIMIT; s.cfg_val = 15'h7FFF; s.drain = 1'b1;
        pending_segs.push_back(s);
        s = plain(0, 0, 24'sd9, 24'sd50, 23'd64, 23'd64);
        s.cfg_sel = REG_VERTEX_LIMIT; s.cfg_val = 15'd4096; s.drain = 1'b1;
        pending_segs.push_back(s);
        // random part: mostly short segments, some wild ones
        for (int i = 0; i < 190; i++)
        begin
            s = rand_seg($urandom_range(0, 3) == 0);
            if (i == 70)
            begin
                s.cfg_sel = REG_INDEX_LIMIT; s.cfg_val = CFG_W'($urandom_range(0, 2000));
                s.drain = 1'b1;
            end
            if (i == 140)
            begin
                s.cfg_sel = REG_INDEX_LIMIT; s.cfg_val = 15'd16384; s.drain = 1'b1;
            end
            if (i == 100) s.drain = 1'b1;
            pending_segs.push_back(s);
        end
    end

    // release reset
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // driver: present one beat at a time from the queue
    always @(negedge clk)
    begin
        seg_t s;
        logic nv_in;
        logic nv_cfg;
        if (rst_n)
        begin
            if (!stim_done)
            begin
                nv_in  = in_valid;
                nv_cfg = 1'b0;
                if (in_valid && in_ready_q)
                    nv_in = 1'b0;
                if ((!in_valid || in_ready_q) && !cfg_write && !hold_off)
                begin
                    if (pending_segs.size() == 0)
                    begin
                        stim_done <= 1'b1;
                    end
                    else if ($urandom_range(0, 99) >= send_idle)
                    begin
                        s = pending_segs[0];
                        if (s.drain && !(mesh_beats.size() == 0 && quiet >= 200))
                            hold_off <= 1'b1;
                        else if (s.cfg_sel >= 0)
                        begin
                            nv_cfg = 1'b1;
                            cfg_index <= s.cfg_sel[0];
                            cfg_data  <= s.cfg_val;
                            if (s.cfg_sel[0] == REG_VERTEX_LIMIT) lim_vtx = s.cfg_val[12:0];
                            else lim_idx = s.cfg_val;
                            pending_segs[0].cfg_sel = -1;
                            pending_segs[0].drain = 1'b0;
                        end
                        else
                        begin
                            void'(pending_segs.pop_front());
                            nv_in = 1'b1;
                            operation <= s.op;
                            start_x <= s.x1; start_y <= s.y1;
                            end_x <= s.x2; end_y <= s.y2;
                            line_width <= s.lw; feather_width <= s.fw;
                            colour_in <= s.col;
                            tessellate(s);
                        end
                    end
                end
                else if (hold_off && mesh_beats.size() == 0 && quiet >= 200)
                begin
                    hold_off <= 1'b0;
                    pending_segs[0].drain = 1'b0;
                end
                in_valid  <= nv_in;
                cfg_write <= nv_cfg;
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // note acceptance seen at the rising edge; count cycles with no output beat
    always @(posedge clk)
    begin
        in_ready_q <= in_valid && in_ready;
        if (in_valid && in_ready)
        begin
            taken++;
            if (taken == 80) begin send_idle = 86; recv_idle = 17; end
            if (taken == 160) begin send_idle = 0; recv_idle = 0; end
        end
        quiet <= (out_valid && out_ready) ? 0 : quiet + 1;
    end

    // monitor: compare each output beat with the oldest prediction
    always @(posedge clk)
    begin
        beat_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (mesh_beats.size() == 0)
            begin
                $display("unexpected output beat at %0t", $realtime);
                errors++;
            end
            else
            begin
                w = mesh_beats.pop_front();
                if (is_triangle !== w.tri_flag) report("is_triangle", is_triangle, w.tri_flag);
                if (vertex_x !== w.vx) report("vertex_x", vertex_x, w.vx);
                if (vertex_y !== w.vy) report("vertex_y", vertex_y, w.vy);
                if (vertex_colour !== w.vc) report("vertex_colour", vertex_colour, w.vc);
                if (vertex_number !== w.vn) report("vertex_number", vertex_number, w.vn);
                if (tri_a !== w.ta) report("tri_a", tri_a, w.ta);
                if (tri_b !== w.tb) report("tri_b", tri_b, w.tb);
                if (tri_c !== w.tc) report("tri_c", tri_c, w.tc);
                if (last !== w.lst) report("last", last, w.lst);
            end
        end
    end

    // watchdog on cycles with no accepted beat on either channel
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 20000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // finish once everything has drained
    initial
    begin
        wait (stim_done && !in_valid);
        wait (mesh_beats.size() == 0);
        repeat (300) @(posedge clk);
        if (errors == 0 && mesh_beats.size() == 0)
            $display("== PASS ==");
        else
        begin
            if (mesh_beats.size() != 0)
                $display("%0d predicted beats never came", mesh_beats.size());
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
